// ----- rtl/ssas_pkg.sv -----
// Shared constants, types and the sequencer control store for the SIR agent step core.
package ssas_pkg;

  // Field widths
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int RAND_W      = 32;
  localparam int CNT_FIELD_W = 21;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Probability format: Q0.PROB_BITS internally, Q1.PROB_BITS for the power result
  localparam int PROB_BITS = 32;
  // Half width of the shared multiplier; each product is four MUL_H x MUL_H terms
  localparam int MUL_H     = (PROB_BITS + 1) / 2;

  localparam int MAX_AGENTS_DEF = 1048576;

  // Op codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_FRAME = 2'd1;
  localparam logic [OP_W-1:0] OP_AGENT = 2'd2;

  // Agent state codes
  localparam logic [ST_W-1:0] ST_NONE = 2'd0;
  localparam logic [ST_W-1:0] ST_SUSC = 2'd1;
  localparam logic [ST_W-1:0] ST_INF  = 2'd2;
  localparam logic [ST_W-1:0] ST_REC  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAY_PROB   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SUSC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_INF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_REC    = 3'd4;

  // Sequencer program addresses
  typedef logic [2:0] upc_t;
  localparam upc_t UA_INIT = 3'd0;
  localparam upc_t UA_SQ   = 3'd1;
  localparam upc_t UA_TEST = 3'd2;
  localparam upc_t UA_MB   = 3'd3;
  localparam upc_t UA_LOOP = 3'd4;
  localparam upc_t UA_DONE = 3'd5;

  // Sequencing condition of one control word
  typedef enum logic [1:0] {
    UC_NEXT,    // fall through
    UC_MUL,     // hold until the multiply finishes, then fall through
    UC_BITCLR,  // jump to target if the current exponent bit is clear
    UC_LOOP     // while bits remain: step down one bit and jump to target
  } ucond_t;

  typedef struct packed {
    logic   acc_init;  // load 1.0 and the top exponent bit
    logic   mul_en;    // run the shared multiplier into the accumulator
    logic   mul_base;  // second operand is the base, else the accumulator
    logic   done;      // store the power and return the result
    ucond_t cond;
    upc_t   target;
  } uword_t;

  // Control store: square-and-multiply over the bits of the infected count
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    w = '0;
    unique case (pc)
      UA_INIT: begin
        w.acc_init = 1'b1;
        w.cond     = UC_NEXT;
      end
      UA_SQ: begin
        w.mul_en = 1'b1;
        w.cond   = UC_MUL;
      end
      UA_TEST: begin
        w.cond   = UC_BITCLR;
        w.target = UA_LOOP;
      end
      UA_MB: begin
        w.mul_en   = 1'b1;
        w.mul_base = 1'b1;
        w.cond     = UC_MUL;
      end
      UA_LOOP: begin
        w.cond   = UC_LOOP;
        w.target = UA_SQ;
      end
      UA_DONE: begin
        w.done = 1'b1;
        w.cond = UC_NEXT;
      end
      default: begin
        w.done = 1'b1;
        w.cond = UC_NEXT;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/ssas_in_if.sv -----
// Input channel interface: valid/ready with op, agent state and random word.
interface ssas_in_if import ssas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ST_W-1:0]   agent_state;
  logic [RAND_W-1:0] random_value;

  modport source (output valid, output op, output agent_state, output random_value,
                  input ready);
  modport sink   (input valid, input op, input agent_state, input random_value,
                  output ready);
endinterface

// ----- rtl/ssas_out_if.sv -----
// Result channel interface: valid/ready with new state, population totals and error flag.
interface ssas_out_if import ssas_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ST_W-1:0]        new_state;
  logic [CNT_FIELD_W-1:0] susceptible_total;
  logic [CNT_FIELD_W-1:0] infected_total;
  logic [CNT_FIELD_W-1:0] recovered_total;
  logic                   bad_state;

  modport source (output valid, output new_state, output susceptible_total,
                  output infected_total, output recovered_total, output bad_state,
                  input ready);
  modport sink   (input valid, input new_state, input susceptible_total,
                  input infected_total, input recovered_total, input bad_state,
                  output ready);
endinterface

// ----- rtl/stochastic_sir_agent_step_core.sv -----
// Top level: SIR agent step core with a microcoded power sequencer.
//
//  channel  | dir | handshake          | transaction
//  ---------+-----+--------------------+-----------------------------------------------
//  in_ch    | in  | valid/ready        | op, agent_state, random_value
//  out_ch   | out | valid/ready        | new_state, three population totals, bad_state
//  cfg_*    | in  | cfg_we, no wait    | cfg_index selects register, cfg_wdata is data
//
// Load, agent and unused ops finish in the accept cycle; the result sits in the output
// register from the cycle after, so one transaction per cycle while out_ch drains.
// A frame op runs the control store on one shared multiplier that forms each product
// from four half-width terms. For each of the CNT_W bits of the infected count, top
// bit first, it squares the accumulator and multiplies by the base if the bit is set.
// in_ch.ready is low while the sequencer runs or while a result waits on a stalled
// out_ch. rst_n is synchronous and clears counts, power, registers and control.
module stochastic_sir_agent_step_core
  import ssas_pkg::*;
#(
  parameter int MAX_AGENTS = MAX_AGENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ssas_in_if.sink               in_ch,
  ssas_out_if.source            out_ch
);

  localparam int CNT_W = $clog2(MAX_AGENTS + 1);
  localparam int BIT_W = $clog2(CNT_W);
  localparam int CMP_W = (CNT_W > CNT_FIELD_W) ? CNT_W : CNT_FIELD_W;
  localparam int MW    = 2 * MUL_H;
  localparam int PW    = 2 * MW;
  localparam logic [CNT_W-1:0]     MAX_CNT  = CNT_W'(MAX_AGENTS);
  localparam logic [PROB_BITS:0]   ONE_Q    = {1'b1, {PROB_BITS{1'b0}}};
  localparam logic [BIT_W-1:0]     TOP_BIT  = BIT_W'(CNT_W - 1);
  localparam logic [2:0]           MUL_LAST = 3'd5;

  // Align a Q0.32 word to Q0.PROB_BITS
  function automatic logic [PROB_BITS-1:0] align_q32(input logic [31:0] v);
    logic [PROB_BITS+31:0] ext;
    ext = {v, {PROB_BITS{1'b0}}};
    return ext[32 +: PROB_BITS];
  endfunction

  function automatic logic [CNT_W-1:0] sat_load(input logic [CNT_FIELD_W-1:0] v);
    if (CMP_W'(v) > CMP_W'(MAX_AGENTS)) return MAX_CNT;
    return CNT_W'(v);
  endfunction

  // Configuration registers
  logic [31:0]            esc_base_r, stay_r;
  logic [CNT_FIELD_W-1:0] init_sus_r, init_inf_r, init_rec_r;

  // Population counts and frame power
  logic [CNT_W-1:0]     sus_r, inf_r, rec_r;
  logic [CNT_W-1:0]     sus_nxt, inf_nxt, rec_nxt;
  logic [PROB_BITS:0]   escape_r, escape_nxt;

  // Sequencer
  logic                 busy_r, busy_nxt;
  upc_t                 upc_r, upc_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [CNT_W-1:0]     snap_r, snap_nxt;
  logic [PROB_BITS:0]   acc_r, acc_nxt;
  logic [2:0]           phase_r, phase_nxt;
  uword_t               uw;

  // Shared multiplier
  logic [MW-1:0]        a_op, b_op;
  logic [MUL_H-1:0]     a_half, b_half;
  logic [MW-1:0]        pp_r, pp_nxt;
  logic [1:0]           pp_w_r, pp_w_nxt;
  logic [PW-1:0]        prod_r, prod_nxt, pp_shifted;
  logic [PROB_BITS:0]   b_full;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]      ns_r, ns_nxt;
  logic                 bad_r, bad_nxt;
  logic [CNT_W-1:0]     o_sus_r, o_inf_r, o_rec_r;

  logic                 accept, load_out;
  logic [PROB_BITS-1:0] rand_al, stay_al, base_al;

  assign in_ch.ready = !busy_r && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign rand_al     = align_q32(in_ch.random_value);
  assign stay_al     = align_q32(stay_r);
  assign base_al     = align_q32(esc_base_r);
  assign uw          = ucode(upc_r);

  // Multiplier operands; phase bits pick the halves, low/low first
  assign a_op   = MW'(acc_r[PROB_BITS-1:0]);
  assign b_op   = uw.mul_base ? MW'(base_al) : MW'(acc_r[PROB_BITS-1:0]);
  assign a_half = phase_r[1] ? a_op[MW-1:MUL_H] : a_op[MUL_H-1:0];
  assign b_half = phase_r[0] ? b_op[MW-1:MUL_H] : b_op[MUL_H-1:0];
  assign pp_nxt   = MW'(a_half) * MW'(b_half);
  assign pp_w_nxt = {1'b0, phase_r[0]} + {1'b0, phase_r[1]};
  assign b_full   = uw.mul_base ? {1'b0, base_al} : acc_r;

  always_comb begin
    case (pp_w_r)
      2'd0:    pp_shifted = PW'(pp_r);
      2'd1:    pp_shifted = PW'(pp_r) << MUL_H;
      default: pp_shifted = PW'(pp_r) << MW;
    endcase
  end

  // Clear on the first phase, add the previous term on every later phase
  assign prod_nxt = (phase_r == '0) ? '0 : prod_r + pp_shifted;

  // Sequencer and counts
  always_comb begin
    sus_nxt    = sus_r;
    inf_nxt    = inf_r;
    rec_nxt    = rec_r;
    escape_nxt = escape_r;
    busy_nxt   = busy_r;
    upc_nxt    = upc_r;
    bit_nxt    = bit_r;
    snap_nxt   = snap_r;
    acc_nxt    = acc_r;
    phase_nxt  = '0;
    ns_nxt     = ST_NONE;
    bad_nxt    = 1'b0;
    load_out   = 1'b0;

    if (busy_r) begin
      if (uw.acc_init) begin
        acc_nxt = ONE_Q;
        bit_nxt = TOP_BIT;
      end
      if (uw.done) begin
        escape_nxt = acc_r;
        busy_nxt   = 1'b0;
        load_out   = 1'b1;
      end
      case (uw.cond)
        UC_NEXT: upc_nxt = upc_r + 3'd1;
        UC_MUL: begin
          if (phase_r == MUL_LAST) begin
            // A product whose accumulator operand is exactly 1.0 passes the other operand through
            acc_nxt = acc_r[PROB_BITS] ? b_full : {1'b0, prod_r[PROB_BITS +: PROB_BITS]};
            upc_nxt = upc_r + 3'd1;
          end else begin
            phase_nxt = phase_r + 3'd1;
          end
        end
        UC_BITCLR: upc_nxt = snap_r[bit_r] ? upc_r + 3'd1 : uw.target;
        UC_LOOP: begin
          if (bit_r != '0) begin
            bit_nxt = bit_r - 1'b1;
            upc_nxt = uw.target;
          end else begin
            upc_nxt = upc_r + 3'd1;
          end
        end
        default: upc_nxt = upc_r + 3'd1;
      endcase
    end else if (accept) begin
      case (in_ch.op)
        OP_LOAD: begin
          sus_nxt  = sat_load(init_sus_r);
          inf_nxt  = sat_load(init_inf_r);
          rec_nxt  = sat_load(init_rec_r);
          load_out = 1'b1;
        end
        OP_FRAME: begin
          // Snapshot the infected count and start the power program
          snap_nxt = inf_r;
          busy_nxt = 1'b1;
          upc_nxt  = UA_INIT;
        end
        OP_AGENT: begin
          load_out = 1'b1;
          case (in_ch.agent_state)
            ST_SUSC: begin
              if ({1'b0, rand_al} < escape_r) begin
                ns_nxt = ST_SUSC;
              end else begin
                ns_nxt = ST_INF;
                if (sus_r != '0) sus_nxt = sus_r - 1'b1;
                if (inf_r < MAX_CNT) inf_nxt = inf_r + 1'b1;
              end
            end
            ST_INF: begin
              if (rand_al < stay_al) begin
                ns_nxt = ST_INF;
              end else begin
                ns_nxt = ST_REC;
                if (inf_r != '0) inf_nxt = inf_r - 1'b1;
                if (rec_r < MAX_CNT) rec_nxt = rec_r + 1'b1;
              end
            end
            ST_REC:  ns_nxt  = ST_REC;
            default: bad_nxt = 1'b1;
          endcase
        end
        default: load_out = 1'b1;
      endcase
    end
  end

  always_comb begin
    if (load_out)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_base_r  <= '0;
      stay_r      <= '0;
      init_sus_r  <= '0;
      init_inf_r  <= '0;
      init_rec_r  <= '0;
      sus_r       <= '0;
      inf_r       <= '0;
      rec_r       <= '0;
      escape_r    <= '0;
      busy_r      <= 1'b0;
      upc_r       <= UA_INIT;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ESCAPE_BASE: esc_base_r <= cfg_wdata;
          CFG_STAY_PROB:   stay_r     <= cfg_wdata;
          CFG_INIT_SUSC:   init_sus_r <= cfg_wdata[CNT_FIELD_W-1:0];
          CFG_INIT_INF:    init_inf_r <= cfg_wdata[CNT_FIELD_W-1:0];
          CFG_INIT_REC:    init_rec_r <= cfg_wdata[CNT_FIELD_W-1:0];
          default: ;
        endcase
      end
      sus_r       <= sus_nxt;
      inf_r       <= inf_nxt;
      rec_r       <= rec_nxt;
      escape_r    <= escape_nxt;
      busy_r      <= busy_nxt;
      upc_r       <= upc_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath payload, no reset
  always_ff @(posedge clk) begin
    bit_r  <= bit_nxt;
    snap_r <= snap_nxt;
    acc_r  <= acc_nxt;
    pp_r   <= pp_nxt;
    pp_w_r <= pp_w_nxt;
    prod_r <= prod_nxt;
    if (load_out) begin
      ns_r    <= ns_nxt;
      bad_r   <= bad_nxt;
      o_sus_r <= sus_nxt;
      o_inf_r <= inf_nxt;
      o_rec_r <= rec_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.new_state         = ns_r;
  assign out_ch.bad_state         = bad_r;
  assign out_ch.susceptible_total = CNT_FIELD_W'(o_sus_r);
  assign out_ch.infected_total    = CNT_FIELD_W'(o_inf_r);
  assign out_ch.recovered_total   = CNT_FIELD_W'(o_rec_r);

`ifndef SYNTHESIS
  // No transaction is taken while the power program runs
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ch.ready)
    else $error("input accepted while sequencer busy");

  // The accumulator never exceeds 1.0
  a_acc_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && acc_r[PROB_BITS]) |-> (acc_r[PROB_BITS-1:0] == '0))
    else $error("power accumulator above 1.0");

  // The output slot is free when the frame result is written
  a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && uw.done) |-> !out_valid_r)
    else $error("frame result would overwrite a pending result");

  // Multiply phases only advance inside a multiply step
  a_phase_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != '0) |-> (busy_r && uw.mul_en && $past(phase_r) == phase_r - 3'd1))
    else $error("multiplier phase out of sequence");

  // The frame result holds the power that the program produced
  a_escape_update: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && uw.done) |=> (escape_r == $past(acc_r)) && !busy_r)
    else $error("frame power not stored");
`endif

endmodule
